[rtl/positional_doubly_linked_list_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the positional doubly linked list
// Immediate-implication and next-cycle-implication property shorthands.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_DOUBLY_LINKED_LIST_ASSERT_SVH
`define POSITIONAL_DOUBLY_LINKED_LIST_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PDLL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pdll assertion failed");

// antecedent implies consequent in the next cycle
`define PDLL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pdll assertion failed");

`endif

[rtl/pdll_pkg.sv]
// ---------------------------------------------------------------------------
// pdll_pkg
// Shared types and constants of the positional doubly linked list.
// ---------------------------------------------------------------------------
package pdll_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned OpW         = 3;
  localparam int unsigned PosW        = 6;
  localparam int unsigned StW         = 2;
  localparam int unsigned LenW        = 5;
  localparam int unsigned CapacityDef = 16;

  typedef enum logic [OpW-1:0] {
    OP_LIST      = 3'd0,
    OP_INS_FRONT = 3'd1,
    OP_INS_END   = 3'd2,
    OP_INS_AT    = 3'd3,
    OP_DEL_FIRST = 3'd4,
    OP_DEL_LAST  = 3'd5,
    OP_DEL_AT    = 3'd6
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } st_e;

  typedef enum logic [1:0] {
    WS_ZERO     = 2'd0,
    WS_COUNT_M1 = 2'd1,
    WS_POS_M1   = 2'd2,
    WS_POS_M2   = 2'd3
  } walk_sel_e;

  typedef enum logic [1:0] {
    RD_TGT  = 2'd0,
    RD_CUR  = 2'd1,
    RD_WALK = 2'd2
  } rd_sel_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_WALK, S_LK_RD, S_LK_W1, S_LK_W2,
    S_UL_RD, S_UL_W, S_LS_RD, S_LS_EM, S_EMIT
  } ctl_state_e;

  typedef struct packed {
    logic      load;
    logic      walk_init;
    walk_sel_e walk_sel;
    logic      walk_step;
    logic      tgt_set;
    logic      tgt_null;
    logic      alloc;
    logic      link_w1;
    logic      link_w2;
    logic      unlink_w;
    logic      list_init;
    logic      list_em;
    logic      emit;
    st_e       st;
    rd_sel_e   rd_sel;
  } cmd_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           empty;
    logic           full;
    logic           ins_bad;
    logic           del_bad;
    logic           pos_one;
    logic           steps_zero;
    logic           lst_fin;
    logic           out_free;
  } sts_t;

endpackage

[rtl/pdll_in_if.sv]
// ---------------------------------------------------------------------------
// pdll_in_if
// Command channel: opcode, value and position with valid/ready.
// ---------------------------------------------------------------------------
interface pdll_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic signed [31:0] value;
  logic [5:0]         position;

  modport source (output valid, opcode, value, position, input ready);
  modport sink   (input valid, opcode, value, position, output ready);
endinterface

[rtl/pdll_out_if.sv]
// ---------------------------------------------------------------------------
// pdll_out_if
// Result channel: value_out, status, last and length with valid/ready.
// ---------------------------------------------------------------------------
interface pdll_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value_out;
  logic [1:0]         status;
  logic               last;
  logic [4:0]         length;

  modport source (output valid, value_out, status, last, length, input ready);
  modport sink   (input valid, value_out, status, last, length, output ready);
endinterface

[rtl/pdll_ram.sv]
// ---------------------------------------------------------------------------
// pdll_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module pdll_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[rtl/pdll_datapath.sv]
// ---------------------------------------------------------------------------
// pdll_datapath
// Node pool RAMs, head/count/occupancy registers, walk pointer, result reg.
// ---------------------------------------------------------------------------
module pdll_datapath #(
  parameter int unsigned CAPACITY = pdll_pkg::CapacityDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [pdll_pkg::OpW-1:0]          opcode_i,
  input  logic signed [pdll_pkg::DataW-1:0] value_i,
  input  logic [pdll_pkg::PosW-1:0]         position_i,
  input  pdll_pkg::cmd_t                    ctl_i,
  output pdll_pkg::sts_t                    sts_o,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output logic signed [pdll_pkg::DataW-1:0] value_out_o,
  output logic [pdll_pkg::StW-1:0]          status_o,
  output logic                              last_o,
  output logic [pdll_pkg::LenW-1:0]         length_o
);
  import pdll_pkg::*;

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned IW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = ((IW > PosW) ? IW : PosW) + 1;
  localparam logic [IW-1:0] NullIdx = IW'(CAPACITY);

  logic [OpW-1:0]          op_q;
  logic signed [DataW-1:0] val_q;
  logic [PosW-1:0]         pos_q;
  logic [IW-1:0]           head_q, count_q, cur_q, tgt_q, nx_q, steps_q;
  logic [AW-1:0]           n_q;
  logic                    rdv_q;
  logic [CAPACITY-1:0]     used_q;

  logic                    out_valid_q;
  logic signed [DataW-1:0] out_val_q;
  logic [StW-1:0]          out_st_q;
  logic                    out_last_q;
  logic [LenW-1:0]         out_len_q;

  logic [IW-1:0]    nxt_rd, prv_rd, cur_eff, rd_idx, nx_c, steps_init;
  logic [DataW-1:0] val_rd;
  logic [AW-1:0]    free_idx;
  logic             tgt_ok, nx_ok, p_ok, x_ok, out_free, out_load;
  logic [CMPW-1:0]  pos_ext, cnt_ext;

  logic             nxt_we, prv_we;
  logic [AW-1:0]    nxt_wa, prv_wa;
  logic [IW-1:0]    nxt_wd, prv_wd;

  assign cur_eff = rdv_q ? nxt_rd : cur_q;
  assign tgt_ok  = tgt_q < NullIdx;
  assign nx_c    = tgt_ok ? nxt_rd : head_q;
  assign nx_ok   = nx_q < NullIdx;
  assign p_ok    = prv_rd < NullIdx;
  assign x_ok    = nxt_rd < NullIdx;
  assign pos_ext = CMPW'(pos_q);
  assign cnt_ext = CMPW'(count_q);

  always_comb begin
    unique case (ctl_i.rd_sel)
      RD_WALK: rd_idx = cur_eff;
      RD_CUR:  rd_idx = cur_q;
      default: rd_idx = tgt_q;
    endcase
  end

  // lowest free pool slot
  always_comb begin
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used_q[i]) free_idx = AW'(i);
    end
  end

  always_comb begin
    unique case (ctl_i.walk_sel)
      WS_COUNT_M1: steps_init = count_q - IW'(1);
      WS_POS_M1:   steps_init = IW'(pos_ext - CMPW'(1));
      WS_POS_M2:   steps_init = IW'(pos_ext - CMPW'(2));
      default:     steps_init = '0;
    endcase
  end

  // link RAM write ports
  always_comb begin
    nxt_we = 1'b0;
    nxt_wa = n_q;
    nxt_wd = nx_c;
    prv_we = 1'b0;
    prv_wa = n_q;
    prv_wd = tgt_q;
    if (ctl_i.link_w1) begin
      nxt_we = 1'b1;
      prv_we = 1'b1;
    end else if (ctl_i.link_w2) begin
      nxt_we = tgt_ok;
      nxt_wa = tgt_q[AW-1:0];
      nxt_wd = IW'(n_q);
      prv_we = nx_ok;
      prv_wa = nx_q[AW-1:0];
      prv_wd = IW'(n_q);
    end else if (ctl_i.unlink_w) begin
      nxt_we = p_ok;
      nxt_wa = prv_rd[AW-1:0];
      nxt_wd = nxt_rd;
      prv_we = x_ok;
      prv_wa = nxt_rd[AW-1:0];
      prv_wd = prv_rd;
    end
  end

  pdll_ram #(.Width(DataW), .Depth(CAPACITY)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.link_w1),
    .waddr_i (n_q),
    .wdata_i (val_q),
    .raddr_i (rd_idx[AW-1:0]),
    .rdata_o (val_rd)
  );

  pdll_ram #(.Width(IW), .Depth(CAPACITY)) u_nxt_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_wa),
    .wdata_i (nxt_wd),
    .raddr_i (rd_idx[AW-1:0]),
    .rdata_o (nxt_rd)
  );

  pdll_ram #(.Width(IW), .Depth(CAPACITY)) u_prv_ram (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_wa),
    .wdata_i (prv_wd),
    .raddr_i (rd_idx[AW-1:0]),
    .rdata_o (prv_rd)
  );

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q  <= opcode_i;
      val_q <= value_i;
      pos_q <= position_i;
    end
    if (ctl_i.walk_init || ctl_i.list_init) begin
      cur_q   <= head_q;
      rdv_q   <= 1'b0;
      steps_q <= ctl_i.list_init ? count_q : steps_init;
    end else if (ctl_i.walk_step) begin
      cur_q   <= cur_eff;
      rdv_q   <= 1'b1;
      steps_q <= steps_q - IW'(1);
    end else if (ctl_i.list_em) begin
      cur_q   <= nxt_rd;
      steps_q <= steps_q - IW'(1);
    end
    if (ctl_i.tgt_set) begin
      tgt_q <= cur_eff;
    end else if (ctl_i.tgt_null) begin
      tgt_q <= NullIdx;
    end
    if (ctl_i.alloc) n_q <= free_idx;
    if (ctl_i.link_w1) nx_q <= nx_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= NullIdx;
      count_q <= '0;
      used_q  <= '0;
    end else if (ctl_i.link_w2) begin
      if (!tgt_ok) head_q <= IW'(n_q);
      used_q[n_q] <= 1'b1;
      count_q     <= count_q + IW'(1);
    end else if (ctl_i.unlink_w) begin
      if (!p_ok) head_q <= nxt_rd;
      used_q[tgt_q[AW-1:0]] <= 1'b0;
      count_q               <= count_q - IW'(1);
    end
  end

  assign out_free = !out_valid_q || res_ready_i;
  assign out_load = ctl_i.emit || ctl_i.list_em;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_val_q  <= ctl_i.list_em ? val_rd : '0;
      out_st_q   <= ctl_i.list_em ? ST_OK : ctl_i.st;
      out_last_q <= ctl_i.list_em ? sts_o.lst_fin : 1'b1;
      out_len_q  <= LenW'(count_q);
    end
  end

  assign sts_o.op         = op_q;
  assign sts_o.empty      = count_q == '0;
  assign sts_o.full       = count_q >= NullIdx;
  assign sts_o.ins_bad    = (pos_q == '0) || (pos_ext > cnt_ext + CMPW'(1));
  assign sts_o.del_bad    = (pos_q == '0) || (pos_ext > cnt_ext);
  assign sts_o.pos_one    = pos_q == PosW'(1);
  assign sts_o.steps_zero = steps_q == '0;
  assign sts_o.lst_fin    = !x_ok || (steps_q == IW'(1));
  assign sts_o.out_free   = out_free;

  assign res_valid_o = out_valid_q;
  assign value_out_o = out_val_q;
  assign status_o    = out_st_q;
  assign last_o      = out_last_q;
  assign length_o    = out_len_q;
endmodule

[rtl/pdll_ctrl.sv]
// ---------------------------------------------------------------------------
// pdll_ctrl
// Command sequencer: decode, link walk, relink writes and result issue.
// ---------------------------------------------------------------------------
module pdll_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  pdll_pkg::sts_t sts_i,
  output pdll_pkg::cmd_t ctl_o
);
  import pdll_pkg::*;

  ctl_state_e state_q, state_d;
  st_e        st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    st_d        = st_q;
    ctl_o       = '0;
    ctl_o.st    = st_q;
    cmd_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          ctl_o.load = 1'b1;
          st_d       = ST_OK;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_EMIT;
        unique case (op_e'(sts_i.op))
          OP_LIST: begin
            if (sts_i.empty) begin
              st_d = ST_EMPTY;
            end else begin
              ctl_o.list_init = 1'b1;
              state_d         = S_LS_RD;
            end
          end
          OP_INS_FRONT: begin
            if (sts_i.full) begin
              st_d = ST_FULL;
            end else begin
              ctl_o.tgt_null = 1'b1;
              state_d        = S_LK_RD;
            end
          end
          OP_INS_END: begin
            if (sts_i.full) begin
              st_d = ST_FULL;
            end else if (sts_i.empty) begin
              ctl_o.tgt_null = 1'b1;
              state_d        = S_LK_RD;
            end else begin
              ctl_o.walk_init = 1'b1;
              ctl_o.walk_sel  = WS_COUNT_M1;
              state_d         = S_WALK;
            end
          end
          OP_INS_AT: begin
            if (sts_i.full) begin
              st_d = ST_FULL;
            end else if (sts_i.empty || (!sts_i.ins_bad && sts_i.pos_one)) begin
              ctl_o.tgt_null = 1'b1;
              state_d        = S_LK_RD;
            end else if (sts_i.ins_bad) begin
              st_d = ST_BADPOS;
            end else begin
              ctl_o.walk_init = 1'b1;
              ctl_o.walk_sel  = WS_POS_M2;
              state_d         = S_WALK;
            end
          end
          OP_DEL_FIRST, OP_DEL_LAST: begin
            if (sts_i.empty) begin
              st_d = ST_EMPTY;
            end else begin
              ctl_o.walk_init = 1'b1;
              ctl_o.walk_sel  = (op_e'(sts_i.op) == OP_DEL_FIRST) ? WS_ZERO : WS_COUNT_M1;
              state_d         = S_WALK;
            end
          end
          OP_DEL_AT: begin
            if (sts_i.empty) begin
              st_d = ST_EMPTY;
            end else if (sts_i.del_bad) begin
              st_d = ST_BADPOS;
            end else begin
              ctl_o.walk_init = 1'b1;
              ctl_o.walk_sel  = WS_POS_M1;
              state_d         = S_WALK;
            end
          end
          default: ;
        endcase
      end
      S_WALK: begin
        ctl_o.rd_sel = RD_WALK;
        if (sts_i.steps_zero) begin
          ctl_o.tgt_set = 1'b1;
          state_d = (op_e'(sts_i.op) == OP_DEL_FIRST || op_e'(sts_i.op) == OP_DEL_LAST ||
                     op_e'(sts_i.op) == OP_DEL_AT) ? S_UL_RD : S_LK_RD;
        end else begin
          ctl_o.walk_step = 1'b1;
        end
      end
      S_LK_RD: begin
        ctl_o.alloc = 1'b1;
        state_d     = S_LK_W1;
      end
      S_LK_W1: begin
        ctl_o.link_w1 = 1'b1;
        state_d       = S_LK_W2;
      end
      S_LK_W2: begin
        ctl_o.link_w2 = 1'b1;
        state_d       = S_EMIT;
      end
      S_UL_RD: begin
        state_d = S_UL_W;
      end
      S_UL_W: begin
        ctl_o.unlink_w = 1'b1;
        state_d        = S_EMIT;
      end
      S_LS_RD: begin
        ctl_o.rd_sel = RD_CUR;
        state_d      = S_LS_EM;
      end
      S_LS_EM: begin
        // read address held so RAM data stays put while the output stalls
        ctl_o.rd_sel = RD_CUR;
        if (sts_i.out_free) begin
          ctl_o.list_em = 1'b1;
          state_d       = sts_i.lst_fin ? S_IDLE : S_LS_RD;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          ctl_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

[rtl/positional_doubly_linked_list.sv]
// Command transfer to result: a rejected command goes from decode to the result;
// insert and delete first walk the links when needed, then relink. List-all emits
// one result per link, each after a registered read of that link, and holds while
// the output stalls. A new command is taken only in idle. One command at a time.
// Reset (async, active low) empties the list; node RAMs keep no reset.
// ---------------------------------------------------------------------------
// positional_doubly_linked_list
// Bounded ordered list of signed words on a doubly linked node pool.
// ---------------------------------------------------------------------------
module positional_doubly_linked_list #(
  parameter int unsigned CAPACITY = pdll_pkg::CapacityDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pdll_in_if.sink   cmd_i,
  pdll_out_if.source res_o
);
  import pdll_pkg::*;

  cmd_t ctl;
  sts_t sts;

  pdll_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  pdll_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .opcode_i    (cmd_i.opcode),
    .value_i     (cmd_i.value),
    .position_i  (cmd_i.position),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .value_out_o (res_o.value_out),
    .status_o    (res_o.status),
    .last_o      (res_o.last),
    .length_o    (res_o.length)
  );
endmodule

[rtl/pdll_checker.sv]
// ---------------------------------------------------------------------------
// pdll_checker
// Port-level checks of the list's result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "positional_doubly_linked_list_assert.svh"

module pdll_checker #(
  parameter int unsigned CAPACITY = pdll_pkg::CapacityDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] value_out,
  input logic [1:0]  status,
  input logic        last,
  input logic [4:0]  length
);
  import pdll_pkg::*;

  `PDLL_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(value_out) && $stable(status) && $stable(last) && $stable(length))
  `PDLL_ASSERT_IMP(a_non_list_zero, res_valid && (status != ST_OK), (value_out == '0) && last)
  `PDLL_ASSERT_IMP(a_empty_len, res_valid && (status == ST_EMPTY), length == '0)
  `PDLL_ASSERT_IMP(a_full_len, res_valid && (status == ST_FULL), length == 5'(CAPACITY))
endmodule

bind positional_doubly_linked_list pdll_checker #(.CAPACITY(CAPACITY)) u_pdll_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .res_valid (res_o.valid),
  .res_ready (res_o.ready),
  .value_out (res_o.value_out),
  .status    (res_o.status),
  .last      (res_o.last),
  .length    (res_o.length)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Drives list commands into the linked list block and checks every result
// transfer against an array-based prediction of the ordered list.
// ---------------------------------------------------------------------------
module tb;
  import pdll_pkg::*;

  localparam int unsigned Cap      = CapacityDef;
  localparam int unsigned MaxCycle = 2000000;
  localparam logic [2:0]  OpUnused = 3'd7;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] value;
    logic [5:0]         position;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic [1:0]         status;
    logic               last;
    logic [4:0]         length;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pdll_in_if  cmd_if ();
  pdll_out_if res_if ();

  positional_doubly_linked_list #(.CAPACITY(Cap)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if.sink),
    .res_o (res_if.source)
  );

  always #10 clk_i = ~clk_i;

  cmd_t              cmd_queue[$];
  res_t              expected_q[$];
  logic signed [31:0] list_vals[$];
  int                errors = 0;
  int unsigned       cycle_cnt = 0;
  bit                send_calm = 1'b0;
  bit                recv_calm = 1'b0;
  bit                send_hold = 1'b0;
  bit                recv_hold = 1'b0;

  // Ordered-list prediction; pool slots are invisible from outside.
  task automatic predict_list(input cmd_t c);
    res_t r;
    int unsigned n;
    n = list_vals.size();
    r = '0;
    r.last = 1'b1;
    r.status = ST_OK;
    case (c.opcode)
      OP_LIST: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
          expected_q.push_back(r);
        end else begin
          for (int k = 0; k < n; k++) begin
            r.value_out = list_vals[k];
            r.last = (k == n - 1);
            r.length = 5'(n);
            expected_q.push_back(r);
          end
        end
        return;
      end
      OP_INS_FRONT, OP_INS_END, OP_INS_AT: begin
        if (n >= Cap) r.status = ST_FULL;
        else if (c.opcode == OP_INS_FRONT || n == 0) list_vals.push_front(c.value);
        else if (c.opcode == OP_INS_END) list_vals.push_back(c.value);
        else if (c.position < 1 || c.position > n + 1) r.status = ST_BADPOS;
        else list_vals.insert(c.position - 1, c.value);
      end
      OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
        if (n == 0) r.status = ST_EMPTY;
        else if (c.opcode == OP_DEL_FIRST) list_vals.delete(0);
        else if (c.opcode == OP_DEL_LAST) list_vals.delete(n - 1);
        else if (c.position < 1 || c.position > n) r.status = ST_BADPOS;
        else list_vals.delete(c.position - 1);
      end
      default: ;
    endcase
    r.length = 5'(list_vals.size());
    expected_q.push_back(r);
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 4))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_cmd(input logic [2:0] op, input logic signed [31:0] v,
                         input logic [5:0] p);
    cmd_t c;
    c.opcode = op;
    c.value = v;
    c.position = p;
    cmd_queue.push_back(c);
  endtask

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
      cmd_if.opcode <= '0;
      cmd_if.value <= '0;
      cmd_if.position <= '0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        predict_list(cmd_queue.pop_front());
      end
      if (cmd_if.valid && !cmd_if.ready) begin
        // hold the offered item
      end else if (cmd_queue.size() > 0 && !send_hold &&
                   (send_calm || $urandom_range(0, 99) >= 32)) begin
        cmd_if.valid <= 1'b1;
        cmd_if.opcode <= cmd_queue[0].opcode;
        cmd_if.value <= cmd_queue[0].value;
        cmd_if.position <= cmd_queue[0].position;
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (res_if.valid && res_if.ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer value=%0d status=%0d last=%0b length=%0d",
                   $time, res_if.value_out, res_if.status, res_if.last, res_if.length);
        end else begin
          res_t e;
          e = expected_q.pop_front();
          if (res_if.value_out !== e.value_out || res_if.status !== e.status ||
              res_if.last !== e.last || res_if.length !== e.length) begin
            errors++;
            $display("%0t: expected value=%0d status=%0d last=%0b length=%0d,",
                     $time, e.value_out, e.status, e.last, e.length);
            $display("%0t:      got value=%0d status=%0d last=%0b length=%0d",
                     $time, res_if.value_out, res_if.status, res_if.last,
                     res_if.length);
          end
        end
      end
      if (recv_hold) begin
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= recv_calm || ($urandom_range(0, 99) >= 32);
      end
      if (cycle_cnt > MaxCycle) begin
        $display("positional_doubly_linked_list: mismatch");
        $finish;
      end
    end
  end

  // Long receiver hold while the sender keeps offering items
  initial begin : recv_hold_proc
    wait (rst_ni);
    repeat (30) @(posedge clk_i);
    recv_hold = 1'b1;
    repeat (300) @(posedge clk_i);
    recv_hold = 1'b0;
  end

  initial begin
    int unsigned n;
    int unsigned op;
    // Directed: empty cases, fill to full, bad positions, extremes
    add_cmd(OP_LIST, '0, '0);
    add_cmd(OP_DEL_FIRST, '0, '0);
    add_cmd(OP_DEL_LAST, '0, '0);
    add_cmd(OP_DEL_AT, '0, 6'd1);
    add_cmd(OP_INS_AT, 32'sh7fff_ffff, 6'd63);
    add_cmd(OP_INS_FRONT, 32'sh8000_0000, '0);
    add_cmd(OP_INS_AT, 32'sd5, '0);
    add_cmd(OP_INS_AT, 32'sd6, 6'd4);
    add_cmd(OP_INS_AT, 32'sd7, 6'd3);
    add_cmd(OP_INS_END, -32'sd1, '0);
    add_cmd(OpUnused, 32'sh5555_aaaa, 6'h2a);
    add_cmd(OP_DEL_AT, '0, '0);
    add_cmd(OP_DEL_AT, '0, 6'd5);
    add_cmd(OP_DEL_AT, '0, 6'd2);
    add_cmd(OP_LIST, '0, '0);
    for (int i = 0; i < 14; i++) add_cmd(OP_INS_END, $urandom(), 6'h15);
    add_cmd(OP_INS_FRONT, 32'sd1, '0);
    add_cmd(OP_INS_AT, 32'sd2, 6'd1);
    add_cmd(OP_LIST, '0, '0);
    add_cmd(OP_DEL_LAST, '0, '0);
    add_cmd(OP_DEL_AT, '0, 6'd16);
    // Random: track expected length loosely to keep positions meaningful
    n = 15;
    for (int i = 0; i < 370; i++) begin
      op = $urandom_range(0, 7);
      if (op >= 1 && op <= 3 && n < Cap) n++;
      else if (op >= 4 && op <= 6 && n > 0 && $urandom_range(0, 3) != 0) n--;
      add_cmd(op[2:0], rand_word(),
              ($urandom_range(0, 9) == 0) ? 6'($urandom()) : 6'($urandom_range(0, n + 1)));
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (recv_hold);
    wait (!recv_hold);
    // Sender pause until every expected result has come
    wait (cmd_queue.size() < 300);
    send_hold = 1'b1;
    wait (!cmd_if.valid && expected_q.size() == 0);
    send_hold = 1'b0;
    // Stretch without idling on either side
    wait (cmd_queue.size() < 200);
    send_calm = 1'b1;
    recv_calm = 1'b1;
    wait (cmd_queue.size() < 120);
    send_calm = 1'b0;
    recv_calm = 1'b0;
    wait (cmd_queue.size() == 0 && !cmd_if.valid);
    wait (expected_q.size() == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("positional_doubly_linked_list: match");
    end else begin
      $display("positional_doubly_linked_list: mismatch");
    end
    $finish;
  end
endmodule

[positional_doubly_linked_list.f]
+incdir+rtl
rtl/pdll_pkg.sv
rtl/pdll_in_if.sv
rtl/pdll_out_if.sv
rtl/pdll_ram.sv
rtl/pdll_datapath.sv
rtl/pdll_ctrl.sv
rtl/positional_doubly_linked_list.sv
rtl/pdll_checker.sv
tb/tb.sv
